[rtl/tbg_pkg.sv]
// shared types, widths and helpers for the two-body gravity step
`timescale 1ns / 1ps

package tbg_pkg;

  localparam int FW        = 32;
  localparam int CW        = 31;
  localparam int FRAC      = 16;
  localparam int DIFF_W    = FW + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int ROOT_W    = 34;
  localparam int GMDT_W    = 2 * CW;
  localparam int PART_W    = CW + DIFF_W;
  localparam int NUM_W     = 111;
  localparam int DEN_W     = 3 * ROOT_W;
  localparam int QBITS     = 40;
  localparam int Q_W       = QBITS + 1;
  localparam int EXT_W     = 48;
  localparam int PROD_W    = 2 * FW;
  localparam int LANES     = 6;
  localparam int DATA_W    = 12 * FW;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GM_FIRST     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GM_SECOND    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 4'd3;

  localparam logic [CW-1:0] RST_GM       = 31'd43741;
  localparam logic [CW-1:0] RST_TIME     = 31'd655;
  localparam logic [CW-1:0] RST_MIN_DIST = 31'd7;

  typedef logic [2:0][FW-1:0] vec3_t;

  // pos_a sits in the lowest bits
  typedef struct packed {
    vec3_t vel_b;
    vec3_t vel_a;
    vec3_t pos_b;
    vec3_t pos_a;
  } state_t;

  function automatic logic [FW-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic [FW-1:0] r;
    if (v > $signed({{(EXT_W-FW+1){1'b0}}, {(FW-1){1'b1}}})) begin
      r = {1'b0, {(FW-1){1'b1}}};
    end else if (v < $signed({{(EXT_W-FW+1){1'b1}}, {(FW-1){1'b0}}})) begin
      r = {1'b1, {(FW-1){1'b0}}};
    end else begin
      r = v[FW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/tbg_delay.sv]
// enabled shift-register delay line for pipeline payload
`timescale 1ns / 1ps

module tbg_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int k = 1; k < N; k++) begin
        pipe_r[k] <= pipe_r[k-1];
      end
    end
  end

  assign q = pipe_r[N-1];

endmodule

[rtl/tbg_isqrt.sv]
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module tbg_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tbg_pkg::SQ_W-1:0]   s,
  output logic [tbg_pkg::ROOT_W-1:0] root
);

  localparam int RW = tbg_pkg::ROOT_W;
  localparam int SW = tbg_pkg::SQ_W;
  localparam int TW = 2 * RW;

  logic [SW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [SW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [TW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = s;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (r + 2^b)^2 - r^2
    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? SW'(TW'(rem_in) - trial) : rem_in;
        root_r[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

[rtl/tbg_div.sv]
// pipelined restoring divider, quotient clamped to 2^40
`timescale 1ns / 1ps

module tbg_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tbg_pkg::NUM_W-1:0] num,
  input  logic [tbg_pkg::DEN_W-1:0] den,
  output logic [tbg_pkg::Q_W-1:0]   quo
);

  localparam int NW = tbg_pkg::NUM_W;
  localparam int DW = tbg_pkg::DEN_W;
  localparam int QB = tbg_pkg::QBITS;
  localparam int XW = DW + QB;

  logic [NW-1:0] rem_r   [QB];
  logic [DW-1:0] den_r   [QB];
  logic [QB-1:0] q_r     [QB+1];
  logic          clamp_r [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= num;
      den_r[0]   <= den;
      q_r[0]     <= '0;
      clamp_r[0] <= XW'(num) >= {den, {QB{1'b0}}};
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int J = QB - k;
    logic [XW-1:0] sub;
    logic          take;

    assign sub  = XW'(den_r[k-1]) << J;
    assign take = XW'(rem_r[k-1]) >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]     <= take ? (q_r[k-1] | (QB'(1) << J)) : q_r[k-1];
        clamp_r[k] <= clamp_r[k-1];
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? NW'(XW'(rem_r[k-1]) - sub) : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = clamp_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_r[QB]};

endmodule

[rtl/two_body_gravity_euler_step.sv]
// top level: two-body gravity semi-implicit euler step pipeline
`timescale 1ns / 1ps

// Streaming two-body gravity update, one semi-implicit Euler step per transaction.
// in_*: one transaction carries both bodies' positions and velocities (Q16.16).
// out_*: one transaction per input with the updated, saturated values, in order.
// cfg_*: register writes (index, data), always ready; write only while idle.
//   index 0 gm_first, 1 gm_second, 2 time_step, 3 min_distance; others ignored.
// From input acceptance to out_tvalid, a transaction passes 3 stages of
// difference, square and numerator forming, 34 square-root stages (one root
// bit each), 3 stages for d^3, 41 divider stages (clamp check plus one
// quotient bit each), then velocity, step product and output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls with a result waiting and the last stage full, the
// whole pipeline holds and in_tready drops until the waiting result is taken.

module two_body_gravity_euler_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pos_a_x/y/z, pos_b_x/y/z, vel_a_x/y/z, vel_b_x/y/z, 32 bits each
  input  logic [tbg_pkg::DATA_W-1:0]    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // new_pos_a_x/y/z, new_pos_b_x/y/z, new_vel_a_x/y/z, new_vel_b_x/y/z
  output logic [tbg_pkg::DATA_W-1:0]    out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbg_pkg::FW-1:0]        cfg_data
);

  localparam int FW       = tbg_pkg::FW;
  localparam int CW       = tbg_pkg::CW;
  localparam int RW       = tbg_pkg::ROOT_W;
  localparam int NW       = tbg_pkg::NUM_W;
  localparam int DW       = tbg_pkg::DEN_W;
  localparam int EW       = tbg_pkg::EXT_W;
  localparam int PW       = tbg_pkg::PROD_W;
  localparam int FR       = tbg_pkg::FRAC;
  localparam int NUM_DLY  = RW + 3;
  localparam int SKIP_DLY = tbg_pkg::QBITS + 3;
  localparam int Q_STAGE  = 3 + RW + 3 + tbg_pkg::QBITS + 1;
  localparam int CAR_DLY  = Q_STAGE - 1;
  localparam int LAST     = Q_STAGE + 2;

  typedef struct packed {
    logic [2:0]       neg;
    tbg_pkg::state_t  st;
  } carry_t;

  logic [CW-1:0] gm_first_r, gm_second_r, time_step_r, min_distance_r;
  logic [tbg_pkg::GMDT_W-1:0] gmdt_a_r, gmdt_b_r;

  logic            adv;
  logic [LAST:1]   vld_r;
  logic            out_tvalid_r, out_load;
  logic [tbg_pkg::DATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_first_r     <= tbg_pkg::RST_GM;
      gm_second_r    <= tbg_pkg::RST_GM;
      time_step_r    <= tbg_pkg::RST_TIME;
      min_distance_r <= tbg_pkg::RST_MIN_DIST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tbg_pkg::REG_GM_FIRST:     gm_first_r     <= cfg_data[CW-1:0];
        tbg_pkg::REG_GM_SECOND:    gm_second_r    <= cfg_data[CW-1:0];
        tbg_pkg::REG_TIME_STEP:    time_step_r    <= cfg_data[CW-1:0];
        tbg_pkg::REG_MIN_DISTANCE: min_distance_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // body one is pulled by body two's parameter and vice versa
  always_ff @(posedge clk) begin
    gmdt_a_r <= gm_second_r * time_step_r;
    gmdt_b_r <= gm_first_r * time_step_r;
  end

  assign adv       = !vld_r[LAST] || !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign out_load  = vld_r[LAST] && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:1], in_tvalid};
    end
  end

  // stage 1: differences
  tbg_pkg::state_t in_st;
  logic [2:0][tbg_pkg::DIFF_W-1:0] diff_nxt, mag_nxt, mag1_r;
  logic [2:0] neg_nxt;
  carry_t car1_r, car81, car82_r, car83_r;

  assign in_st = tbg_pkg::state_t'(in_tdata);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_nxt[i] = {in_st.pos_b[i][FW-1], in_st.pos_b[i]}
                  - {in_st.pos_a[i][FW-1], in_st.pos_a[i]};
      neg_nxt[i]  = diff_nxt[i][tbg_pkg::DIFF_W-1];
      mag_nxt[i]  = neg_nxt[i] ? (~diff_nxt[i] + 1'b1) : diff_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r     <= mag_nxt;
      car1_r.neg <= neg_nxt;
      car1_r.st  <= in_st;
    end
  end

  // stage 2: squares and numerator partial products
  logic [tbg_pkg::SQ_W-1:0]   sq2_r  [3];
  logic [tbg_pkg::PART_W-1:0] nlo2_r [tbg_pkg::LANES];
  logic [tbg_pkg::PART_W-1:0] nhi2_r [tbg_pkg::LANES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i]    <= mag1_r[i] * mag1_r[i];
        nlo2_r[i]   <= gmdt_a_r[CW-1:0] * mag1_r[i];
        nhi2_r[i]   <= gmdt_a_r[tbg_pkg::GMDT_W-1:CW] * mag1_r[i];
        nlo2_r[i+3] <= gmdt_b_r[CW-1:0] * mag1_r[i];
        nhi2_r[i+3] <= gmdt_b_r[tbg_pkg::GMDT_W-1:CW] * mag1_r[i];
      end
    end
  end

  // stage 3: distance squared and full numerators
  logic [tbg_pkg::SQ_W-1:0] s3_r;
  logic [NW-1:0]            num3_r [tbg_pkg::LANES];

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      for (int j = 0; j < tbg_pkg::LANES; j++) begin
        num3_r[j] <= ((NW'(nhi2_r[j]) << CW) + NW'(nlo2_r[j])) << FR;
      end
    end
  end

  logic [RW-1:0] d37;

  tbg_isqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .s    (s3_r),
    .root (d37)
  );

  // d^3 in partial products, threshold check
  logic [RW-1:0]   d38_r;
  logic [2*RW-1:0] d2_38_r, plo39_r, phi39_r;
  logic [DW-1:0]   d3_40_r;
  logic            skip38_r, skip81, skip82_r, skip83_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d38_r    <= d37;
      d2_38_r  <= d37 * d37;
      skip38_r <= (d37 == '0) || (d37 < RW'(min_distance_r));
      plo39_r  <= d2_38_r[RW-1:0] * d38_r;
      phi39_r  <= d2_38_r[2*RW-1:RW] * d38_r;
      d3_40_r  <= DW'(plo39_r) + (DW'(phi39_r) << RW);
    end
  end

  tbg_delay #(.W(1), .N(SKIP_DLY)) u_skip_dly (
    .clk (clk),
    .en  (adv),
    .d   (skip38_r),
    .q   (skip81)
  );

  tbg_delay #(.W($bits(carry_t)), .N(CAR_DLY)) u_car_dly (
    .clk (clk),
    .en  (adv),
    .d   (car1_r),
    .q   (car81)
  );

  logic [NW-1:0]           num40 [tbg_pkg::LANES];
  logic [tbg_pkg::Q_W-1:0] q81   [tbg_pkg::LANES];

  for (genvar j = 0; j < tbg_pkg::LANES; j++) begin : g_lane
    tbg_delay #(.W(NW), .N(NUM_DLY)) u_num_dly (
      .clk (clk),
      .en  (adv),
      .d   (num3_r[j]),
      .q   (num40[j])
    );

    tbg_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num40[j]),
      .den (d3_40_r),
      .quo (q81[j])
    );
  end

  // velocity update
  logic signed [EW-1:0] va_ext, vb_ext, qa_ext, qb_ext;
  logic signed [EW-1:0] sum_nxt [tbg_pkg::LANES];
  logic signed [FW-1:0] nv82_r  [tbg_pkg::LANES];
  logic signed [FW-1:0] nv83_r  [tbg_pkg::LANES];
  logic signed [PW-1:0] prod83_r [tbg_pkg::LANES];
  logic signed [FW-1:0] dt_s;

  always_comb begin
    va_ext = '0;
    vb_ext = '0;
    qa_ext = '0;
    qb_ext = '0;
    for (int i = 0; i < 3; i++) begin
      va_ext = {{(EW-FW){car81.st.vel_a[i][FW-1]}}, car81.st.vel_a[i]};
      vb_ext = {{(EW-FW){car81.st.vel_b[i][FW-1]}}, car81.st.vel_b[i]};
      qa_ext = EW'(q81[i]);
      qb_ext = EW'(q81[i+3]);
      sum_nxt[i]   = car81.neg[i] ? (va_ext - qa_ext) : (va_ext + qa_ext);
      sum_nxt[i+3] = car81.neg[i] ? (vb_ext + qb_ext) : (vb_ext - qb_ext);
    end
  end

  assign dt_s = {1'b0, time_step_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      car82_r  <= car81;
      car83_r  <= car82_r;
      skip82_r <= skip81;
      skip83_r <= skip82_r;
      for (int j = 0; j < tbg_pkg::LANES; j++) begin
        nv82_r[j]   <= tbg_pkg::sat32(sum_nxt[j]);
        nv83_r[j]   <= nv82_r[j];
        prod83_r[j] <= nv82_r[j] * dt_s;
      end
    end
  end

  // position update, truncating toward zero
  logic [PW-1:0]        w_nxt   [tbg_pkg::LANES];
  logic signed [EW-1:0] pos_ext [tbg_pkg::LANES];
  tbg_pkg::state_t      upd_st, out_st;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_ext[i]   = {{(EW-FW){car83_r.st.pos_a[i][FW-1]}}, car83_r.st.pos_a[i]};
      pos_ext[i+3] = {{(EW-FW){car83_r.st.pos_b[i][FW-1]}}, car83_r.st.pos_b[i]};
    end
    for (int j = 0; j < tbg_pkg::LANES; j++) begin
      w_nxt[j] = prod83_r[j] + {{(PW-FR){1'b0}}, {FR{prod83_r[j][PW-1]}}};
    end
    for (int i = 0; i < 3; i++) begin
      upd_st.pos_a[i] = tbg_pkg::sat32(pos_ext[i] + $signed(w_nxt[i][PW-1:FR]));
      upd_st.pos_b[i] = tbg_pkg::sat32(pos_ext[i+3] + $signed(w_nxt[i+3][PW-1:FR]));
      upd_st.vel_a[i] = nv83_r[i];
      upd_st.vel_b[i] = nv83_r[i+3];
    end
    out_st = skip83_r ? car83_r.st : upd_st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_st;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted transaction did not enter the pipeline");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r))
    else $error("pipeline moved while stalled");

  a_drain : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !vld_r[LAST] |=> !out_tvalid)
    else $error("result repeated after it was taken");

  a_passthrough : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && skip83_r && adv |=> out_tdata == $past(car83_r.st))
    else $error("close pair was not passed through");

endmodule

[bench/tb_top.sv]
// self-checking testbench for the two-body gravity euler step stream
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [tbg_pkg::DATA_W-1:0] data;
    bit                         known;
    logic [tbg_pkg::DATA_W-1:0] result;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [tbg_pkg::DATA_W-1:0]    in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [tbg_pkg::DATA_W-1:0]    out_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tbg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tbg_pkg::FW-1:0]        cfg_data = '0;

  logic [tbg_pkg::CW-1:0] gm_a_cur = tbg_pkg::RST_GM;
  logic [tbg_pkg::CW-1:0] gm_b_cur = tbg_pkg::RST_GM;
  logic [tbg_pkg::CW-1:0] dt_cur = tbg_pkg::RST_TIME;
  logic [tbg_pkg::CW-1:0] dmin_cur = tbg_pkg::RST_MIN_DIST;

  logic [tbg_pkg::DATA_W-1:0] next_states_q[$];
  bit                         known_q[$];
  logic [tbg_pkg::DATA_W-1:0] known_res_q[$];
  stim_row_t                  rows[$];
  int                         errors = 0;
  int                         n_sent = 0;
  int                         n_checked = 0;
  int                         burst_left = 0;
  bit                         gaps_on = 1'b1;
  bit                         hold_req = 1'b0;

  two_body_gravity_euler_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint accel_dv(logic [tbg_pkg::CW-1:0] gm, longint diff,
                                      logic [135:0] d3);
    logic [135:0] m;
    logic [135:0] q;
    m = (diff < 0) ? -diff : diff;
    q = ((136'(gm) * m * 136'(dt_cur)) << 16) / d3;
    if (q >= (136'(1) << tbg_pkg::QBITS)) q = 136'(1) << tbg_pkg::QBITS;
    return (diff < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint drift(longint pos, longint vel);
    longint prod;
    longint stp;
    prod = vel * longint'({33'd0, dt_cur});
    stp = ((prod < 0) ? -prod : prod) >>> 16;
    return clamp32(pos + ((prod < 0) ? -stp : stp));
  endfunction

  function automatic logic [tbg_pkg::DATA_W-1:0] euler_update(
      logic [tbg_pkg::DATA_W-1:0] din);
    tbg_pkg::state_t s;
    tbg_pkg::state_t r;
    longint pa, pb, va, vb, diff[3], nva, nvb;
    logic [135:0] sum, cand, d3;
    logic [33:0] root;
    s = din;
    sum = '0;
    root = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = longint'($signed(s.pos_b[i])) - longint'($signed(s.pos_a[i]));
      cand = (diff[i] < 0) ? -diff[i] : diff[i];
      sum = sum + cand * cand;
    end
    for (int b = 33; b >= 0; b--) begin
      cand = 136'(root | (34'd1 << b));
      if (cand * cand <= sum) root = cand[33:0];
    end
    if (root == 0 || root < 34'(dmin_cur)) return din;
    d3 = 136'(root) * 136'(root) * 136'(root);
    for (int i = 0; i < 3; i++) begin
      pa = $signed(s.pos_a[i]);
      pb = $signed(s.pos_b[i]);
      va = $signed(s.vel_a[i]);
      vb = $signed(s.vel_b[i]);
      nva = clamp32(va + accel_dv(gm_b_cur, diff[i], d3));
      nvb = clamp32(vb - accel_dv(gm_a_cur, diff[i], d3));
      r.vel_a[i] = nva[31:0];
      r.vel_b[i] = nvb[31:0];
      r.pos_a[i] = 32'(drift(pa, nva));
      r.pos_b[i] = 32'(drift(pb, nvb));
    end
    return r;
  endfunction

  // prediction and config tracking on accepted transactions
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        tbg_pkg::REG_GM_FIRST:     gm_a_cur <= cfg_data[tbg_pkg::CW-1:0];
        tbg_pkg::REG_GM_SECOND:    gm_b_cur <= cfg_data[tbg_pkg::CW-1:0];
        tbg_pkg::REG_TIME_STEP:    dt_cur <= cfg_data[tbg_pkg::CW-1:0];
        tbg_pkg::REG_MIN_DISTANCE: dmin_cur <= cfg_data[tbg_pkg::CW-1:0];
        default: ;
      endcase
    end
    if (rst_n && in_tvalid && in_tready) begin
      next_states_q.push_back(euler_update(in_tdata));
      n_sent++;
    end
  end

  always @(posedge clk) begin
    logic [tbg_pkg::DATA_W-1:0] want;
    logic [tbg_pkg::DATA_W-1:0] row_res;
    bit                         row_known;
    if (rst_n && out_tvalid && out_tready) begin
      if (next_states_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_tdata);
      end else begin
        want = next_states_q.pop_front();
        if (known_q.size() != 0) begin
          row_known = known_q.pop_front();
          row_res = known_res_q.pop_front();
          if (row_known && row_res !== want) begin
            errors++;
            $display("%0t: table row expected %h predicted %h", $time, row_res, want);
          end
        end
        for (int f = 0; f < 12; f++) begin
          if (out_tdata[f*tbg_pkg::FW +: tbg_pkg::FW] !== want[f*tbg_pkg::FW +: tbg_pkg::FW])
          begin
            errors++;
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     want[f*tbg_pkg::FW +: tbg_pkg::FW],
                     out_tdata[f*tbg_pkg::FW +: tbg_pkg::FW]);
          end
        end
        n_checked++;
      end
    end
  end

  initial begin
    int mode;
    mode = 0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(logic [tbg_pkg::CFG_IDX_W-1:0] idx, logic [tbg_pkg::FW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pair(logic [tbg_pkg::DATA_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (next_states_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [tbg_pkg::DATA_W-1:0] pack_pair(logic [31:0] pa[3],
      logic [31:0] pb[3], logic [31:0] va[3], logic [31:0] vb[3]);
    tbg_pkg::state_t s;
    for (int i = 0; i < 3; i++) begin
      s.pos_a[i] = pa[i];
      s.pos_b[i] = pb[i];
      s.vel_a[i] = va[i];
      s.vel_b[i] = vb[i];
    end
    return s;
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] base, int unsigned span);
    return base + ($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [tbg_pkg::DATA_W-1:0] random_pair();
    logic [31:0] pa[3], pb[3], va[3], vb[3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      pa[i] = $urandom;
      pb[i] = $urandom;
      va[i] = $urandom;
      vb[i] = $urandom;
      case (kind)
        0, 1: ;
        2: pb[i] = pa[i];
        3: pb[i] = jitter(pa[i], 64);
        4, 5, 6: begin
          pa[i] = jitter(32'd0, 1 << 24);
          pb[i] = jitter(pa[i], 1 << 20);
          va[i] = jitter(32'd0, 1 << 20);
          vb[i] = jitter(32'd0, 1 << 20);
        end
        default: begin
          pa[i] = jitter(32'd0, 1 << 28);
          pb[i] = jitter(pa[i], 1 << 16);
        end
      endcase
    end
    return pack_pair(pa, pb, va, vb);
  endfunction

  task automatic add_row(logic [31:0] pa[3], logic [31:0] pb[3], logic [31:0] va[3],
                         logic [31:0] vb[3], bit still);
    stim_row_t r;
    r.data = pack_pair(pa, pb, va, vb);
    r.known = still;
    r.result = r.data;
    rows.push_back(r);
  endtask

  task automatic build_table();
    logic [31:0] z[3], mx[3], mn[3], a[3], b[3], c[3];
    z = '{32'd0, 32'd0, 32'd0};
    mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    mn = '{32'h80000000, 32'h80000000, 32'h80000000};
    add_row(z, z, z, z, 1'b1);
    add_row(mx, mx, mx, mn, 1'b1);
    add_row(mn, mn, mn, mx, 1'b1);
    a = '{32'd3, 32'd0, 32'd0};
    add_row(z, a, mx, mn, 1'b1);
    a = '{32'd0, 32'd4, 32'd0};
    b = '{32'd0, 32'd0, 32'd5};
    add_row(a, b, z, z, 1'b1);
    a = '{32'd7, 32'd0, 32'd0};
    add_row(z, a, z, z, 1'b0);
    add_row(mn, mx, z, z, 1'b0);
    add_row(mx, mn, mx, mn, 1'b0);
    a = '{32'h00010000, 32'd0, 32'd0};
    add_row(z, a, z, z, 1'b0);
    add_row(a, z, mx, mn, 1'b0);
    b = '{32'h7fff0000, 32'h7fff0000, 32'h7fff0000};
    c = '{32'h7ff00000, 32'h7fff0000, 32'h7fff0000};
    add_row(b, c, mx, mx, 1'b0);
    a = '{32'h55555555, 32'h55555555, 32'h55555555};
    b = '{32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa};
    add_row(a, b, b, a, 1'b0);
    add_row(b, a, a, b, 1'b0);
    a = '{32'hfffe0000, 32'h00020000, 32'hffff8000};
    add_row(z, a, a, z, 1'b0);
  endtask

  function automatic logic [tbg_pkg::FW-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return {$urandom_range(0, 1) == 1, 31'h7fffffff};
      2: return $urandom;
      3: return $urandom_range(0, 1 << 12);
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  initial begin
    build_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[k]) begin
      known_q.push_back(rows[k].known);
      known_res_q.push_back(rows[k].result);
      send_pair(rows[k].data);
    end
    drain();
    known_q.delete();
    known_res_q.delete();
    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: begin
          cfg_write(tbg_pkg::REG_GM_FIRST, 32'hffffffff);
          cfg_write(tbg_pkg::REG_GM_SECOND, 32'h7fffffff);
          cfg_write(tbg_pkg::REG_TIME_STEP, 32'h7fffffff);
          cfg_write(tbg_pkg::REG_MIN_DISTANCE, 32'd0);
        end
        2: begin
          cfg_write(tbg_pkg::REG_GM_FIRST, 32'd0);
          cfg_write(tbg_pkg::REG_GM_SECOND, 32'd0);
          cfg_write(tbg_pkg::REG_TIME_STEP, 32'd0);
          cfg_write(tbg_pkg::REG_MIN_DISTANCE, 32'd0);
          hold_req = 1'b1;
        end
        3: begin
          cfg_write(tbg_pkg::REG_GM_FIRST, 32'h00010000);
          cfg_write(tbg_pkg::REG_GM_SECOND, 32'h00100000);
          cfg_write(tbg_pkg::REG_TIME_STEP, 32'h00001000);
          cfg_write(tbg_pkg::REG_MIN_DISTANCE, 32'h7fffffff);
        end
        default: begin
          cfg_write(tbg_pkg::REG_GM_FIRST, pick_reg());
          cfg_write(tbg_pkg::REG_GM_SECOND, pick_reg());
          cfg_write(tbg_pkg::REG_TIME_STEP, pick_reg());
          cfg_write(tbg_pkg::REG_MIN_DISTANCE,
                    ($urandom_range(0, 1) == 1) ? 32'd0 : pick_reg());
        end
      endcase
      cfg_write(tbg_pkg::CFG_IDX_W'($urandom_range(4, 15)), $urandom);
      gaps_on = (p % 3 != 0);
      repeat (240) send_pair(random_pair());
      drain();
    end
    $display("sent %0d pairs, checked %0d results over 9 register settings", n_sent, n_checked);
    $display("settings included zero and full-scale gains, step and threshold");
    if (errors == 0 && next_states_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", next_states_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
